// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

// ===== design/dqc_pkg.sv =====
// Shared types and constants of the dual quadrature counter.
`timescale 1ns / 1ps

package dqc_pkg;

    localparam int DEF_COUNT_WIDTH = 32;
    localparam int DEF_CHANNELS    = 2;
    localparam int VAL_WIDTH       = 32;
    localparam int CFG_IDX_WIDTH   = 2;
    localparam int QUEUE_DEPTH     = 2;
    localparam int STEP_DOWN       = -1;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_INVERT_0     = 2'd0,
        REG_INVERT_1     = 2'd1,
        REG_STOP_VALUE_0 = 2'd2,
        REG_STOP_VALUE_1 = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_EDGE,
        CMD_PRESET
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                    kind;
        logic                         ch;
        logic                         up;
        logic signed [VAL_WIDTH-1:0]  preset_0;
        logic signed [VAL_WIDTH-1:0]  preset_1;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== design/dqc_front.sv =====
// Front end: classifies each input item into a counter command.
`timescale 1ns / 1ps

module dqc_front
    import dqc_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic                        i_op,
    input  logic                        i_channel,
    input  logic                        i_edge_on_b,
    input  logic                        i_level_a,
    input  logic                        i_level_b,
    input  logic signed [VAL_WIDTH-1:0] i_preset_0,
    input  logic signed [VAL_WIDTH-1:0] i_preset_1,
    input  logic [1:0]                  i_invert,
    output t_cmd                        o_cmd
);

    logic w_inv;

    always_comb begin
        w_inv          = i_channel ? i_invert[1] : i_invert[0];
        o_cmd.ch       = i_channel;
        o_cmd.up       = (i_level_a == i_level_b) ^ w_inv ^ i_edge_on_b;
        o_cmd.preset_0 = i_preset_0;
        o_cmd.preset_1 = i_preset_1;
        if (i_op) begin
            o_cmd.kind = CMD_PRESET;
        end else if (int'(i_channel) < CHANNELS) begin
            o_cmd.kind = CMD_EDGE;
        end else begin
            o_cmd.kind = CMD_NOP;
        end
    end

endmodule

// ===== design/dqc_queue.sv =====
// Short command queue between the front end and the counter back end.
`timescale 1ns / 1ps

module dqc_queue
    import dqc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_fill;
    logic [PTR_W:0]   n_fill;

    always_comb begin
        n_fill = r_fill;
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_fill <= n_fill;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_fill == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_fill == '0);

endmodule

// ===== design/dqc_back.sv =====
// Back end: applies commands to the position counts and holds the result.
`timescale 1ns / 1ps

module dqc_back
    import dqc_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int CHANNELS    = DEF_CHANNELS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    input  logic                        i_cmd_avail,
    output logic                        o_pop,
    input  logic signed [VAL_WIDTH-1:0] i_stop_value_0,
    input  logic signed [VAL_WIDTH-1:0] i_stop_value_1,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [VAL_WIDTH-1:0]        o_count_0,
    output logic [VAL_WIDTH-1:0]        o_count_1,
    output logic                        o_stop_hit_0,
    output logic                        o_stop_hit_1
);

    localparam int NUM_CNT = (CHANNELS > 1) ? 2 : 1;
    localparam logic [COUNT_WIDTH-1:0] STEP_UP_C   = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] STEP_DOWN_C = COUNT_WIDTH'(STEP_DOWN);

    logic [COUNT_WIDTH-1:0] r_count [NUM_CNT];
    logic [COUNT_WIDTH-1:0] n_count [NUM_CNT];
    logic [COUNT_WIDTH-1:0] w_stop  [NUM_CNT];
    logic [NUM_CNT-1:0]     r_hit;
    logic [NUM_CNT-1:0]     n_hit;
    logic                   r_out_valid;

    assign o_pop = i_cmd_avail && (!r_out_valid || !i_out_stall);

    always_comb begin
        for (int i = 0; i < NUM_CNT; i++) begin
            w_stop[i]  = (i == 0) ? COUNT_WIDTH'(i_stop_value_0)
                                  : COUNT_WIDTH'(i_stop_value_1);
            n_count[i] = r_count[i];
            n_hit[i]   = 1'b0;
            case (i_cmd.kind)
                CMD_PRESET: begin
                    n_count[i] = (i == 0) ? COUNT_WIDTH'(i_cmd.preset_0)
                                          : COUNT_WIDTH'(i_cmd.preset_1);
                end
                CMD_EDGE: begin
                    if (i_cmd.ch == 1'(i)) begin
                        n_count[i] = r_count[i] + (i_cmd.up ? STEP_UP_C : STEP_DOWN_C);
                        n_hit[i]   = (n_count[i] == w_stop[i]);
                    end
                end
                default: begin
                    n_count[i] = r_count[i];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CNT; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                for (int i = 0; i < NUM_CNT; i++) begin
                    r_count[i] <= n_count[i];
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hit <= n_hit;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_count_0    = VAL_WIDTH'(r_count[0]);
    assign o_count_1    = (NUM_CNT > 1) ? VAL_WIDTH'(r_count[NUM_CNT-1]) : '0;
    assign o_stop_hit_0 = r_hit[0];
    assign o_stop_hit_1 = (NUM_CNT > 1) ? r_hit[NUM_CNT-1] : 1'b0;

endmodule

// ===== design/dual_quadrature_counter_top.sv =====
// Top level of the dual quadrature counter with configuration registers.
// Two x4 quadrature position counters. Each transfer on the input channel is
// either an edge event for one channel or a preset of both counts, and yields
// exactly one result carrying both counts and the two stop flags. The block
// takes one transfer per clock cycle while the queue is not full: the front
// end classifies the item into the two-entry command queue, and the back end
// applies it with one count add/compare per cycle, unless the output stalls,
// into the output register. Configuration is written through a plain write
// port, only while the block is idle; the user, not the block, ensures this.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dual_quadrature_counter_top
    import dqc_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int CHANNELS    = DEF_CHANNELS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [VAL_WIDTH-1:0]        i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_op,
    input  logic                        i_channel,
    input  logic                        i_edge_on_b,
    input  logic                        i_level_a,
    input  logic                        i_level_b,
    input  logic signed [VAL_WIDTH-1:0] i_preset_0,
    input  logic signed [VAL_WIDTH-1:0] i_preset_1,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [VAL_WIDTH-1:0] o_count_0,
    output logic signed [VAL_WIDTH-1:0] o_count_1,
    output logic                        o_stop_hit_0,
    output logic                        o_stop_hit_1
);

    logic [1:0]                  r_invert;
    logic signed [VAL_WIDTH-1:0] r_stop_value_0;
    logic signed [VAL_WIDTH-1:0] r_stop_value_1;
    t_cmd                        w_front_cmd;
    t_cmd                        w_queue_cmd;
    t_q_status                   w_q_status;
    logic                        w_push;
    logic                        w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert       <= '0;
            r_stop_value_0 <= '0;
            r_stop_value_1 <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_INVERT_0:     r_invert[0]    <= i_cfg_data[0];
                REG_INVERT_1:     r_invert[1]    <= i_cfg_data[0];
                REG_STOP_VALUE_0: r_stop_value_0 <= i_cfg_data;
                REG_STOP_VALUE_1: r_stop_value_1 <= i_cfg_data;
                default: begin
                    r_invert <= r_invert;
                end
            endcase
        end
    end

    assign o_in_stall = w_q_status.full;
    assign w_push     = i_in_valid && !w_q_status.full;

    dqc_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_op        (i_op),
        .i_channel   (i_channel),
        .i_edge_on_b (i_edge_on_b),
        .i_level_a   (i_level_a),
        .i_level_b   (i_level_b),
        .i_preset_0  (i_preset_0),
        .i_preset_1  (i_preset_1),
        .i_invert    (r_invert),
        .o_cmd       (w_front_cmd)
    );

    dqc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_front_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_queue_cmd),
        .o_status (w_q_status)
    );

    dqc_back #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .CHANNELS    (CHANNELS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_queue_cmd),
        .i_cmd_avail    (!w_q_status.empty),
        .o_pop          (w_pop),
        .i_stop_value_0 (r_stop_value_0),
        .i_stop_value_1 (r_stop_value_1),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_count_0      (o_count_0),
        .o_count_1      (o_count_1),
        .o_stop_hit_0   (o_stop_hit_0),
        .o_stop_hit_1   (o_stop_hit_1)
    );

    `ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid)
    `ASSERT_CLK(a_hits_exclusive, i_clk, i_rst_n, o_out_valid |-> !(o_stop_hit_0 && o_stop_hit_1))
    `ASSERT_CLK(a_queue_status, i_clk, i_rst_n, !(w_q_status.full && w_q_status.empty))
    `ASSERT_CLK(a_pop_needs_cmd, i_clk, i_rst_n, w_pop |-> !w_q_status.empty)

endmodule
